/* sv/dtog_pkg.sv */
// ----------------------------------------------------------------------------
// dtog_pkg
// Shared types and constants for the depth to occupancy grid block.
// ----------------------------------------------------------------------------
`default_nettype none

package dtog_pkg;

    localparam int MAP_ROWS_DEF = 256;
    localparam int MAP_COLS_DEF = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_METERS_PER_UNIT = 3'd0,
        REG_CENTER_COL      = 3'd1,
        REG_CENTER_ROW      = 3'd2,
        REG_INV_FOCAL_COL   = 3'd3,
        REG_INV_FOCAL_ROW   = 3'd4,
        REG_CELLS_PER_METER = 3'd5,
        REG_FLOOR_LIMIT     = 3'd6
    } t_reg_idx;

    localparam logic [31:0] CFG_METERS_PER_UNIT_RST = 32'd4294967;
    localparam logic [15:0] CFG_CENTER_COL_RST      = 16'd5120;
    localparam logic [15:0] CFG_CENTER_ROW_RST      = 16'd3840;
    localparam logic [23:0] CFG_INV_FOCAL_COL_RST   = 24'd31957;
    localparam logic [23:0] CFG_INV_FOCAL_ROW_RST   = 24'd31957;
    localparam logic [15:0] CFG_CELLS_PER_METER_RST = 16'd5120;
    localparam logic [15:0] CFG_FLOOR_LIMIT_RST     = 16'hFF26;

    typedef struct packed {
        logic [31:0] meters_per_unit;
        logic [15:0] center_col;
        logic [15:0] center_row;
        logic [23:0] inv_focal_col;
        logic [23:0] inv_focal_row;
        logic [15:0] cells_per_meter;
        logic [15:0] floor_limit;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_READ   = 2'd2,
        KIND_SAMPLE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  cell_row;
        logic [7:0]  cell_col;
        logic [4:0]  bit_sel;
    } t_cmd;

endpackage

`default_nettype wire

/* sv/depth_to_occupancy_grid_top.sv */
// ----------------------------------------------------------------------------
// depth_to_occupancy_grid_top
// Back-projects depth pixels through a pinhole model into a bit-per-cell
// occupancy grid; a readout transaction returns one map word and clears it.
// ----------------------------------------------------------------------------
// Each transaction yields exactly one result. A front pipeline of five stages
// computes the cell, a two-entry queue decouples it from the map back end,
// which does one read-modify-write of the map memory per transaction (read,
// then write-back) and takes no new transaction until the last one has gone
// to the result register. After reset the block holds full while it zeroes
// the map. Write configuration only while the block is idle.
`default_nettype none

module depth_to_occupancy_grid_top #(
    parameter int MAP_ROWS = dtog_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = dtog_pkg::MAP_COLS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dtog_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dtog_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            i_operation,
    input  wire logic [11:0]                     i_pixel_col,
    input  wire logic [11:0]                     i_pixel_row,
    input  wire logic [15:0]                     i_depth_raw,
    input  wire logic [10:0]                     i_word_index,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 o_cell_marked,
    output logic [7:0]                           o_cell_row,
    output logic [7:0]                           o_cell_col,
    output logic [31:0]                          o_map_bits
);

    localparam int MAP_WORDS = (MAP_ROWS * MAP_COLS + 31) / 32;
    localparam int WAW = $clog2(MAP_WORDS);

    dtog_pkg::t_cfg r_cfg;
    logic           w_front_ready, w_accept, w_clearing;
    logic           w_q_push, w_q_full, w_q_vld, w_q_pop;
    dtog_pkg::t_cmd w_front_cmd, w_q_cmd;
    logic [WAW-1:0] w_front_addr, w_q_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.meters_per_unit <= dtog_pkg::CFG_METERS_PER_UNIT_RST;
            r_cfg.center_col      <= dtog_pkg::CFG_CENTER_COL_RST;
            r_cfg.center_row      <= dtog_pkg::CFG_CENTER_ROW_RST;
            r_cfg.inv_focal_col   <= dtog_pkg::CFG_INV_FOCAL_COL_RST;
            r_cfg.inv_focal_row   <= dtog_pkg::CFG_INV_FOCAL_ROW_RST;
            r_cfg.cells_per_meter <= dtog_pkg::CFG_CELLS_PER_METER_RST;
            r_cfg.floor_limit     <= dtog_pkg::CFG_FLOOR_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (dtog_pkg::t_reg_idx'(i_cfg_index))
                dtog_pkg::REG_METERS_PER_UNIT: r_cfg.meters_per_unit <= i_cfg_data;
                dtog_pkg::REG_CENTER_COL:      r_cfg.center_col      <= i_cfg_data[15:0];
                dtog_pkg::REG_CENTER_ROW:      r_cfg.center_row      <= i_cfg_data[15:0];
                dtog_pkg::REG_INV_FOCAL_COL:   r_cfg.inv_focal_col   <= i_cfg_data[23:0];
                dtog_pkg::REG_INV_FOCAL_ROW:   r_cfg.inv_focal_row   <= i_cfg_data[23:0];
                dtog_pkg::REG_CELLS_PER_METER: r_cfg.cells_per_meter <= i_cfg_data[15:0];
                dtog_pkg::REG_FLOOR_LIMIT:     r_cfg.floor_limit     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign full     = !w_front_ready || w_clearing;
    assign w_accept = push && !full;

    dtog_front #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_operation  (i_operation),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_depth_raw  (i_depth_raw),
        .i_word_index (i_word_index),
        .i_q_full     (w_q_full),
        .o_ready      (w_front_ready),
        .o_push       (w_q_push),
        .o_cmd        (w_front_cmd),
        .o_addr       (w_front_addr)
    );

    dtog_cmdq #(
        .AW (WAW)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .i_addr  (w_front_addr),
        .o_full  (w_q_full),
        .o_vld   (w_q_vld),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd),
        .o_addr  (w_q_addr)
    );

    dtog_back #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_vld       (w_q_vld),
        .i_cmd         (w_q_cmd),
        .i_addr        (w_q_addr),
        .o_q_pop       (w_q_pop),
        .o_clearing    (w_clearing),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_cell_marked (o_cell_marked),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .o_map_bits    (o_map_bits)
    );

endmodule

`default_nettype wire

/* sv/dtog_front.sv */
// ----------------------------------------------------------------------------
// dtog_front
// Classifies items and back-projects depth samples to grid cells in a five-stage
// pipeline that stalls as a whole when its last stage holds an item and the command queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module dtog_front #(
    parameter int MAP_ROWS = dtog_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = dtog_pkg::MAP_COLS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dtog_pkg::t_cfg       i_cfg,
    input  wire logic                 i_accept,
    input  wire logic                 i_operation,
    input  wire logic [11:0]          i_pixel_col,
    input  wire logic [11:0]          i_pixel_row,
    input  wire logic [15:0]          i_depth_raw,
    input  wire logic [10:0]          i_word_index,
    input  wire logic                 i_q_full,
    output logic                      o_ready,
    output logic                      o_push,
    output dtog_pkg::t_cmd            o_cmd,
    output logic [$clog2((MAP_ROWS*MAP_COLS+31)/32)-1:0] o_addr
);

    localparam int MAP_WORDS = (MAP_ROWS * MAP_COLS + 31) / 32;
    localparam int WAW = $clog2(MAP_WORDS);
    localparam int RW  = $clog2(MAP_ROWS);
    localparam int CW  = $clog2(MAP_COLS);
    localparam int CIW = $clog2(MAP_ROWS * MAP_COLS);

    localparam logic [48:0]        LP_ZC_LIM  = 49'(MAP_COLS) << 23;
    localparam logic [24:0]        LP_COL_OFS = 25'(MAP_COLS / 2);
    localparam logic signed [61:0] LP_XC_LIM  = 62'(MAP_ROWS) <<< 23;
    localparam logic signed [61:0] LP_XC_NEG  = -LP_XC_LIM;
    localparam logic signed [62:0] LP_ROW_OFS = 63'(MAP_ROWS / 2) <<< 24;

    logic [4:0] r_vld;
    logic       w_adv;

    // stage 1
    dtog_pkg::t_kind    r_s1_kind, w_s1_kind;
    logic [WAW-1:0]     r_s1_addr;
    logic [31:0]        r_s1_z;
    logic signed [16:0] r_s1_dux, r_s1_duy;
    logic [47:0]        w_z_prod;
    logic signed [16:0] w_dux, w_duy;

    // stage 2
    dtog_pkg::t_kind    r_s2_kind;
    logic [WAW-1:0]     r_s2_addr;
    logic [31:0]        r_s2_z;
    logic signed [28:0] r_s2_slx, r_s2_sly;
    logic [47:0]        r_s2_zc;
    logic signed [41:0] w_px, w_py;
    logic [47:0]        w_zc;

    // stage 3
    dtog_pkg::t_kind    r_s3_kind;
    logic [WAW-1:0]     r_s3_addr;
    logic signed [44:0] r_s3_xq, r_s3_yq;
    logic [CW-1:0]      r_s3_col;
    logic               r_s3_col_ok;
    logic signed [61:0] w_xp, w_yp;
    logic [24:0]        w_col_full;
    logic               w_col_ok;

    // stage 4
    dtog_pkg::t_kind    r_s4_kind;
    logic [WAW-1:0]     r_s4_addr;
    logic signed [61:0] r_s4_xc;
    logic               r_s4_ygt;
    logic [CW-1:0]      r_s4_col;
    logic               r_s4_col_ok;
    logic signed [61:0] w_xc;
    logic signed [23:0] w_flq;

    // stage 5
    dtog_pkg::t_kind    r_s5_kind, w_s5_kind;
    logic [WAW-1:0]     r_s5_addr;
    logic [RW-1:0]      r_s5_row;
    logic [CW-1:0]      r_s5_col;
    logic signed [62:0] w_rt;
    logic               w_row_ok;
    logic [CIW-1:0]     w_cell;

    assign w_adv   = !(r_vld[4] && i_q_full);
    assign o_ready = w_adv;
    assign o_push  = r_vld[4] && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], i_accept};
        end
    end

    assign w_z_prod = 48'(i_depth_raw) * 48'(i_cfg.meters_per_unit);
    assign w_dux = $signed({1'b0, i_pixel_col, 4'h0}) - $signed({1'b0, i_cfg.center_col});
    assign w_duy = $signed({1'b0, i_pixel_row, 4'h0}) - $signed({1'b0, i_cfg.center_row});

    always_comb begin
        if (i_operation) begin
            w_s1_kind = ({21'd0, i_word_index} < 32'(MAP_WORDS)) ?
                        dtog_pkg::KIND_READ : dtog_pkg::KIND_NONE;
        end else begin
            w_s1_kind = (i_depth_raw != 16'd0) ? dtog_pkg::KIND_SAMPLE : dtog_pkg::KIND_NONE;
        end
    end

    assign w_px = 42'(r_s1_dux) * $signed({18'd0, i_cfg.inv_focal_col});
    assign w_py = 42'(r_s1_duy) * $signed({18'd0, i_cfg.inv_focal_row});
    assign w_zc = 48'(r_s1_z) * 48'(i_cfg.cells_per_meter);

    assign w_xp = 62'(r_s2_slx) * $signed({30'd0, r_s2_z});
    assign w_yp = 62'(r_s2_sly) * $signed({30'd0, r_s2_z});
    assign w_col_full = {1'b0, r_s2_zc[47:24]} + LP_COL_OFS;
    assign w_col_ok = ({1'b0, r_s2_zc} < LP_ZC_LIM) && (w_col_full < 25'(MAP_COLS));

    assign w_xc  = 62'(r_s3_xq) * $signed({46'd0, i_cfg.cells_per_meter});
    assign w_flq = $signed({i_cfg.floor_limit, 8'h00});

    assign w_rt = 63'(r_s4_xc) + LP_ROW_OFS;
    assign w_row_ok = (r_s4_xc > LP_XC_NEG) && (r_s4_xc < LP_XC_LIM) && !w_rt[62] &&
                      (w_rt[62:24] < 39'(MAP_ROWS));

    always_comb begin
        if (r_s4_kind == dtog_pkg::KIND_SAMPLE) begin
            w_s5_kind = (w_row_ok && r_s4_col_ok && r_s4_ygt) ?
                        dtog_pkg::KIND_MARK : dtog_pkg::KIND_NONE;
        end else begin
            w_s5_kind = r_s4_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_kind   <= w_s1_kind;
            r_s1_addr   <= WAW'(i_word_index);
            r_s1_z      <= w_z_prod[47:16];
            r_s1_dux    <= w_dux;
            r_s1_duy    <= w_duy;

            r_s2_kind   <= r_s1_kind;
            r_s2_addr   <= r_s1_addr;
            r_s2_z      <= r_s1_z;
            r_s2_slx    <= w_px[40:12];
            r_s2_sly    <= w_py[40:12];
            r_s2_zc     <= w_zc;

            r_s3_kind   <= r_s2_kind;
            r_s3_addr   <= r_s2_addr;
            r_s3_xq     <= w_xp[60:16];
            r_s3_yq     <= w_yp[60:16];
            r_s3_col    <= CW'(w_col_full);
            r_s3_col_ok <= w_col_ok;

            r_s4_kind   <= r_s3_kind;
            r_s4_addr   <= r_s3_addr;
            r_s4_xc     <= w_xc;
            r_s4_ygt    <= r_s3_yq > 45'(w_flq);
            r_s4_col    <= r_s3_col;
            r_s4_col_ok <= r_s3_col_ok;

            r_s5_kind   <= w_s5_kind;
            r_s5_addr   <= r_s4_addr;
            r_s5_row    <= w_rt[24 +: RW];
            r_s5_col    <= r_s4_col;
        end
    end

    assign w_cell = CIW'(r_s5_row) * CIW'(MAP_COLS) + CIW'(r_s5_col);

    always_comb begin
        o_cmd.kind     = r_s5_kind;
        o_cmd.cell_row = 8'(r_s5_row);
        o_cmd.cell_col = 8'(r_s5_col);
        o_cmd.bit_sel  = w_cell[4:0];
        o_addr = (r_s5_kind == dtog_pkg::KIND_MARK) ? WAW'(w_cell >> 5) : r_s5_addr;
    end

endmodule

`default_nettype wire

/* sv/dtog_cmdq.sv */
// ----------------------------------------------------------------------------
// dtog_cmdq
// Short command queue between the projection front end and the map back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dtog_cmdq #(
    parameter int AW = 11
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dtog_pkg::t_cmd i_cmd,
    input  wire logic [AW-1:0]  i_addr,
    output logic                o_full,
    output logic                o_vld,
    input  wire logic           i_pop,
    output dtog_pkg::t_cmd      o_cmd,
    output logic [AW-1:0]       o_addr
);

    dtog_pkg::t_cmd                   r_cmd  [dtog_pkg::CMDQ_DEPTH];
    logic [AW-1:0]                    r_addr [dtog_pkg::CMDQ_DEPTH];
    logic [dtog_pkg::CMDQ_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [dtog_pkg::CMDQ_PTR_W:0]    r_count;
    logic                             w_wr, w_rd;

    assign o_full = (r_count == (dtog_pkg::CMDQ_PTR_W+1)'(dtog_pkg::CMDQ_DEPTH));
    assign o_vld  = (r_count != '0);
    assign w_wr   = i_push && !o_full;
    assign w_rd   = i_pop && o_vld;
    assign o_cmd  = r_cmd[r_rd_ptr];
    assign o_addr = r_addr[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_cmd[r_wr_ptr]  <= i_cmd;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

endmodule

`default_nettype wire

/* sv/dtog_back.sv */
// ----------------------------------------------------------------------------
// dtog_back
// Occupancy map memory: clearing pass after reset, read-modify-write per
// command, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtog_back #(
    parameter int MAP_ROWS = dtog_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = dtog_pkg::MAP_COLS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_vld,
    input  wire dtog_pkg::t_cmd i_cmd,
    input  wire logic [$clog2((MAP_ROWS*MAP_COLS+31)/32)-1:0] i_addr,
    output logic                o_q_pop,
    output logic                o_clearing,
    output logic                o_empty,
    input  wire logic           i_pop,
    output logic                o_cell_marked,
    output logic [7:0]          o_cell_row,
    output logic [7:0]          o_cell_col,
    output logic [31:0]         o_map_bits
);

    localparam int MAP_WORDS = (MAP_ROWS * MAP_COLS + 31) / 32;
    localparam int WAW = $clog2(MAP_WORDS);

    logic [31:0]    r_mem [MAP_WORDS];
    logic           r_clearing;
    logic [WAW-1:0] r_clr_addr;

    logic           r_rmw_vld;
    dtog_pkg::t_cmd r_rmw_cmd;
    logic [WAW-1:0] r_rmw_addr;
    logic [31:0]    r_rdata;

    logic           r_out_vld;

    logic           w_issue, w_out_free, w_done, w_we;
    logic [WAW-1:0] w_waddr;
    logic [31:0]    w_wdata;

    assign w_issue    = !r_clearing && i_q_vld && !r_rmw_vld;
    assign w_out_free = !r_out_vld || i_pop;
    assign w_done     = r_rmw_vld && w_out_free;
    assign o_q_pop    = w_issue;
    assign o_clearing = r_clearing;
    assign o_empty    = !r_out_vld;

    always_comb begin
        w_we    = r_clearing || (w_done && ((r_rmw_cmd.kind == dtog_pkg::KIND_MARK) ||
                                            (r_rmw_cmd.kind == dtog_pkg::KIND_READ)));
        w_waddr = r_clearing ? r_clr_addr : r_rmw_addr;
        if (r_clearing || (r_rmw_cmd.kind == dtog_pkg::KIND_READ)) begin
            w_wdata = '0;
        end else begin
            w_wdata = r_rdata | (32'd1 << r_rmw_cmd.bit_sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_issue) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == WAW'(MAP_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmw_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_issue) begin
                r_rmw_vld <= 1'b1;
            end else if (w_done) begin
                r_rmw_vld <= 1'b0;
            end
            if (w_done) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rmw_cmd  <= i_cmd;
            r_rmw_addr <= i_addr;
        end
        if (w_done) begin
            o_cell_marked <= (r_rmw_cmd.kind == dtog_pkg::KIND_MARK);
            o_cell_row    <= (r_rmw_cmd.kind == dtog_pkg::KIND_MARK) ? r_rmw_cmd.cell_row : 8'd0;
            o_cell_col    <= (r_rmw_cmd.kind == dtog_pkg::KIND_MARK) ? r_rmw_cmd.cell_col : 8'd0;
            o_map_bits    <= (r_rmw_cmd.kind == dtog_pkg::KIND_READ) ? r_rdata : 32'd0;
        end
    end

endmodule

`default_nettype wire

/* sv/dtog_checker.sv */
// ----------------------------------------------------------------------------
// dtog_port_checker
// Port-level checks on the result side of the occupancy grid block.
// ----------------------------------------------------------------------------
`default_nettype none

module dtog_port_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        full,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic        o_cell_marked,
    input  wire logic [7:0]  o_cell_row,
    input  wire logic [7:0]  o_cell_col,
    input  wire logic [31:0] o_map_bits
);

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("block not full and empty after reset");

    a_mark_no_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cell_marked) |-> (o_map_bits == 32'd0))
        else $error("marked result carries map bits");

    a_unmarked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_cell_marked) |-> (o_cell_row == 8'd0 && o_cell_col == 8'd0))
        else $error("unmarked result carries a cell");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_cell_marked) && $stable(o_cell_row) &&
                              $stable(o_cell_col) && $stable(o_map_bits)))
        else $error("stalled result changed");

endmodule

bind depth_to_occupancy_grid_top dtog_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_cell_marked (o_cell_marked),
    .o_cell_row    (o_cell_row),
    .o_cell_col    (o_cell_col),
    .o_map_bits    (o_map_bits)
);

`default_nettype wire

/* test/dtog_checker.sv */
// ----------------------------------------------------------------------------
// dtog_checker
// Scoreboard for the depth to occupancy grid block. Watches the register
// port and both queue channels, keeps its own copy of the registers and the
// occupancy map, predicts one result per accepted transaction and compares
// every popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtog_tb_pkg;

    localparam bit OP_SAMPLE = 1'b0;
    localparam bit OP_READ   = 1'b1;

endpackage

module dtog_checker
    import dtog_pkg::*;
    import dtog_tb_pkg::*;
#(
    parameter int MAP_ROWS = MAP_ROWS_DEF,
    parameter int MAP_COLS = MAP_COLS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_push,
    input  wire logic                  i_full,
    input  wire logic                  i_operation,
    input  wire logic [11:0]           i_pixel_col,
    input  wire logic [11:0]           i_pixel_row,
    input  wire logic [15:0]           i_depth_raw,
    input  wire logic [10:0]           i_word_index,
    input  wire logic                  i_empty,
    input  wire logic                  i_pop,
    input  wire logic                  i_cell_marked,
    input  wire logic [7:0]            i_cell_row,
    input  wire logic [7:0]            i_cell_col,
    input  wire logic [31:0]           i_map_bits,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_marks
);

    localparam int     MAP_WORDS = (MAP_ROWS * MAP_COLS + 31) / 32;
    localparam longint ROW_SPAN  = longint'(MAP_ROWS) <<< 24;
    localparam longint COL_SPAN  = longint'(MAP_COLS) <<< 24;
    localparam longint ROW_HALF  = longint'(MAP_ROWS / 2) <<< 24;
    localparam longint COL_HALF  = longint'(MAP_COLS / 2) <<< 24;

    typedef struct packed {
        bit        marked;
        bit [7:0]  row;
        bit [7:0]  col;
        bit [31:0] bits;
    } grid_result_t;

    grid_result_t    pending_results[$];
    bit [31:0]       grid_words[MAP_WORDS];

    bit [31:0]       meters_per_unit;
    bit [15:0]       center_col;
    bit [15:0]       center_row;
    bit [23:0]       inv_focal_col;
    bit [23:0]       inv_focal_row;
    bit [15:0]       cells_per_meter;
    bit signed [15:0] floor_limit;

    // Q.16 meters along one image axis, all shifts are floors
    function automatic longint axis_offset(bit [11:0] pix, bit [15:0] center,
                                           bit [23:0] inv_focal, longint zq);
        longint du;
        longint slope;
        du    = longint'(pix) * 16 - longint'(center);
        slope = (du * longint'(inv_focal)) >>> 12;
        return (slope * zq) >>> 16;
    endfunction

    function automatic grid_result_t project_transaction(bit op, bit [11:0] u,
                                                         bit [11:0] v, bit [15:0] d,
                                                         bit [10:0] w);
        grid_result_t r;
        bit [63:0]    prod;
        longint       zq, xq, yq, xc, zc, rt, ct, row, col;
        int           cell_idx;
        r = '0;
        if (op == OP_READ) begin
            if (w < MAP_WORDS) begin
                r.bits = grid_words[w];
                grid_words[w] = '0;
            end
            return r;
        end
        if (d == 0)
            return r;
        prod = 64'(d) * 64'(meters_per_unit);
        zq   = longint'(prod >> 16);
        xq   = axis_offset(u, center_col, inv_focal_col, zq);
        yq   = axis_offset(v, center_row, inv_focal_row, zq);
        xc   = xq * longint'(cells_per_meter);
        zc   = zq * longint'(cells_per_meter);
        if (2 * xc <= -ROW_SPAN || 2 * xc >= ROW_SPAN || 2 * zc >= COL_SPAN)
            return r;
        if (yq <= longint'(floor_limit) * 256)
            return r;
        rt = xc + ROW_HALF;
        ct = zc + COL_HALF;
        if (rt < 0 || ct < 0)
            return r;
        row = rt >>> 24;
        col = ct >>> 24;
        if (row >= MAP_ROWS || col >= MAP_COLS)
            return r;
        cell_idx = int'(row * MAP_COLS + col);
        grid_words[cell_idx >> 5][cell_idx & 31] = 1'b1;
        r.marked = 1'b1;
        r.row    = row[7:0];
        r.col    = col[7:0];
        return r;
    endfunction

    function automatic int field_mismatch(string name, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        grid_result_t exp_r;
        if (!i_rst_n) begin
            meters_per_unit = CFG_METERS_PER_UNIT_RST;
            center_col      = CFG_CENTER_COL_RST;
            center_row      = CFG_CENTER_ROW_RST;
            inv_focal_col   = CFG_INV_FOCAL_COL_RST;
            inv_focal_row   = CFG_INV_FOCAL_ROW_RST;
            cells_per_meter = CFG_CELLS_PER_METER_RST;
            floor_limit     = CFG_FLOOR_LIMIT_RST;
            foreach (grid_words[i])
                grid_words[i] = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_METERS_PER_UNIT: meters_per_unit = i_cfg_data;
                    REG_CENTER_COL:      center_col      = i_cfg_data[15:0];
                    REG_CENTER_ROW:      center_row      = i_cfg_data[15:0];
                    REG_INV_FOCAL_COL:   inv_focal_col   = i_cfg_data[23:0];
                    REG_INV_FOCAL_ROW:   inv_focal_row   = i_cfg_data[23:0];
                    REG_CELLS_PER_METER: cells_per_meter = i_cfg_data[15:0];
                    REG_FLOOR_LIMIT:     floor_limit     = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0b/%0d/%0d/0x%0h",
                             $time, i_cell_marked, i_cell_row, i_cell_col, i_map_bits);
                    o_errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    o_errors += field_mismatch("cell_marked", 32'(exp_r.marked),
                                               32'(i_cell_marked));
                    o_errors += field_mismatch("cell_row", 32'(exp_r.row), 32'(i_cell_row));
                    o_errors += field_mismatch("cell_col", 32'(exp_r.col), 32'(i_cell_col));
                    o_errors += field_mismatch("map_bits", exp_r.bits, i_map_bits);
                    if (exp_r.marked)
                        o_marks++;
                end
            end
            if (i_push && !i_full)
                pending_results.push_back(project_transaction(i_operation, i_pixel_col,
                                                              i_pixel_row, i_depth_raw,
                                                              i_word_index));
        end
        o_pending = pending_results.size();
    end

endmodule

/* test/depth_to_occupancy_grid_top_test.sv */
// ----------------------------------------------------------------------------
// depth_to_occupancy_grid_top_test
// Drives depth samples and map readouts into the occupancy grid block under
// several register settings, with bursty pushes and a stalling consumer; the
// checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_to_occupancy_grid_top_test;

    import dtog_pkg::*;
    import dtog_tb_pkg::*;

    typedef enum {DRAIN_STEADY, DRAIN_RANDOM, DRAIN_SPARSE} drain_mode_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  push        = 1'b0;
    logic                  full;
    logic                  operation   = 1'b0;
    logic [11:0]           pixel_col   = '0;
    logic [11:0]           pixel_row   = '0;
    logic [15:0]           depth_raw   = '0;
    logic [10:0]           word_index  = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic                  cell_marked;
    logic [7:0]            cell_row;
    logic [7:0]            cell_col;
    logic [31:0]           map_bits;

    int          errors;
    int          pending;
    int          marks;
    int          n_items    = 0;
    int          n_reads    = 0;
    int          n_settings = 1;
    int          burst_left = 4;
    int          drain_left = 0;
    drain_mode_t drain_mode = DRAIN_STEADY;

    depth_to_occupancy_grid_top u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .push          (push),
        .full          (full),
        .i_operation   (operation),
        .i_pixel_col   (pixel_col),
        .i_pixel_row   (pixel_row),
        .i_depth_raw   (depth_raw),
        .i_word_index  (word_index),
        .empty         (empty),
        .pop           (pop),
        .o_cell_marked (cell_marked),
        .o_cell_row    (cell_row),
        .o_cell_col    (cell_col),
        .o_map_bits    (map_bits)
    );

    dtog_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_operation   (operation),
        .i_pixel_col   (pixel_col),
        .i_pixel_row   (pixel_row),
        .i_depth_raw   (depth_raw),
        .i_word_index  (word_index),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_cell_marked (cell_marked),
        .i_cell_row    (cell_row),
        .i_cell_col    (cell_col),
        .i_map_bits    (map_bits),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_marks       (marks)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    // consumer: switch between steady, random and sparse pops
    always @(negedge clk) begin
        if (drain_left == 0) begin
            drain_mode = drain_mode_t'($urandom_range(0, 2));
            drain_left = $urandom_range(16, 96);
        end else begin
            drain_left--;
        end
        case (drain_mode)
            DRAIN_STEADY: pop <= 1'b1;
            DRAIN_RANDOM: pop <= 1'($urandom_range(0, 1));
            default:      pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(bit op, bit [11:0] u, bit [11:0] v, bit [15:0] d,
                             bit [10:0] w);
        operation  = op;
        pixel_col  = u;
        pixel_row  = v;
        depth_raw  = d;
        word_index = w;
        push       = 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
        n_items++;
        if (op == OP_READ)
            n_reads++;
        burst_left--;
        if (burst_left <= 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_idle();
        push = 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(t_reg_idx idx, bit [31:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic program_grid(bit [31:0] mpu, bit [15:0] cx, bit [15:0] cy,
                                bit [23:0] fcol, bit [23:0] frow, bit [15:0] cpm,
                                bit [15:0] floor_q);
        wait_idle();
        write_reg(REG_METERS_PER_UNIT, mpu);
        write_reg(REG_CENTER_COL, {16'h0, cx});
        write_reg(REG_CENTER_ROW, {16'h0, cy});
        write_reg(REG_INV_FOCAL_COL, {8'h0, fcol});
        write_reg(REG_INV_FOCAL_ROW, {8'h0, frow});
        write_reg(REG_CELLS_PER_METER, {16'h0, cpm});
        write_reg(REG_FLOOR_LIMIT, {16'h0, floor_q});
        n_settings++;
    endtask

    task automatic send_random();
        bit [11:0] u;
        bit [11:0] v;
        bit [15:0] d;
        bit [10:0] w;
        int        sel;
        sel = $urandom_range(0, 99);
        u   = 12'($urandom);
        v   = 12'($urandom);
        d   = 16'($urandom);
        w   = 11'($urandom);
        if (sel < 55) begin
            send_item(OP_SAMPLE, 12'($urandom_range(0, 639)), 12'($urandom_range(0, 479)),
                      16'($urandom_range(200, 7000)), w);
        end else if (sel < 75) begin
            w = 11'($urandom_range(96, 160) * 8 + $urandom_range(4, 7));
            send_item(OP_READ, u, v, d, w);
        end else if (sel < 85) begin
            send_item(OP_READ, u, v, d, w);
        end else if (sel < 95) begin
            if ($urandom_range(0, 3) == 0)
                u = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            if ($urandom_range(0, 3) == 0)
                v = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            send_item(OP_SAMPLE, u, v, d, w);
        end else begin
            send_item(OP_SAMPLE, u, v, 16'h0, w);
        end
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_random();
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero depth, map edges, floor, repeat mark, readouts
        send_item(OP_SAMPLE, 12'd320, 12'd240, 16'd0, 11'd0);
        send_item(OP_SAMPLE, 12'hFFF, 12'hFFF, 16'd0, 11'h7FF);
        send_item(OP_SAMPLE, 12'hFFF, 12'hFFF, 16'hFFFF, 11'h7FF);
        send_item(OP_SAMPLE, 12'd320, 12'd240, 16'd1000, 11'd0);
        send_item(OP_SAMPLE, 12'd320, 12'd240, 16'd1000, 11'd0);
        send_item(OP_SAMPLE, 12'd0, 12'd0, 16'd1000, 11'd0);
        send_item(OP_SAMPLE, 12'd639, 12'd479, 16'd1000, 11'd0);
        send_item(OP_SAMPLE, 12'd320, 12'd0, 16'd3000, 11'd0);
        send_item(OP_SAMPLE, 12'd320, 12'd240, 16'd6399, 11'd0);
        send_item(OP_SAMPLE, 12'd320, 12'd240, 16'd6400, 11'd0);
        send_item(OP_SAMPLE, 12'd320, 12'd240, 16'd1, 11'd0);
        send_item(OP_SAMPLE, 12'd0, 12'hFFF, 16'd1, 11'd0);
        send_item(OP_SAMPLE, 12'hFFF, 12'd0, 16'd1, 11'd0);
        send_item(OP_READ, 12'hFFF, 12'hFFF, 16'hFFFF, 11'd1028);
        send_item(OP_READ, 12'd0, 12'd0, 16'd0, 11'd1028);
        send_item(OP_READ, 12'd0, 12'd0, 16'd0, 11'd1031);
        send_item(OP_READ, 12'd0, 12'd0, 16'd0, 11'd924);
        send_item(OP_READ, 12'd0, 12'd0, 16'd0, 11'd0);
        send_item(OP_READ, 12'd0, 12'd0, 16'd0, 11'h7FF);

        random_phase(150);
        wait_idle();
        random_phase(150);

        program_grid(32'd2147484, 16'd5200, 16'd3700, 24'd30000, 24'd33000,
                     16'd2560, 16'h0000);
        random_phase(200);

        program_grid(32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 24'd1, 24'hFF_FFFF,
                     16'd1, 16'h8000);
        random_phase(100);

        program_grid(32'd1, 16'hFFFF, 16'h0000, 24'hFF_FFFF, 24'd1,
                     16'hFFFF, 16'h7FFF);
        random_phase(60);

        repeat (3) begin
            program_grid($urandom_range(2000000, 9000000), 16'($urandom_range(3000, 7000)),
                         16'($urandom_range(2000, 6000)), 24'($urandom_range(20000, 60000)),
                         24'($urandom_range(20000, 60000)), 16'($urandom_range(1280, 10240)),
                         16'($signed($urandom_range(0, 1200)) - 1000));
            random_phase(100);
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("Covered %0d transactions (%0d readouts) over %0d register settings.",
                 n_items, n_reads, n_settings);
        $display("Grid cells marked by samples: %0d.", marks);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
